>>> design/gsa_pkg.sv
// Package for the glide slope altitude block: widths, codes, pipeline step functions.
package gsa_pkg;

    localparam int XY_W    = 20;   // horizontal coordinate width
    localparam int ALT_W   = 18;   // altitude width
    localparam int DIF_W   = 21;   // coordinate difference width
    localparam int SQR_W   = 41;   // one squared difference
    localparam int SUM_W   = 42;   // sum of two squares
    localparam int ROOT_W  = 21;   // distance width
    localparam int REM_W   = 23;   // square root partial remainder
    localparam int SQ_STAGES = SUM_W / 2;
    localparam int NUM_W   = 40;   // |here * altitude delta|
    localparam int DV_STAGES = NUM_W;
    localparam int OUT_SUM_W = NUM_W + 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [ALT_W-1:0] ALT_MIN = -18'sd131072;
    localparam logic signed [ALT_W-1:0] ALT_MAX = 18'sd131071;

    // result rule codes
    typedef enum logic [1:0] {
        RULE_INTERP = 2'd0,
        RULE_START  = 2'd1,
        RULE_CLAMP  = 2'd2
    } t_rule;

    // register indexes (paddr word index)
    localparam logic [2:0] REG_START_X   = 3'd0;
    localparam logic [2:0] REG_START_Y   = 3'd1;
    localparam logic [2:0] REG_START_ALT = 3'd2;
    localparam logic [2:0] REG_END_X     = 3'd3;
    localparam logic [2:0] REG_END_Y     = 3'd4;
    localparam logic [2:0] REG_END_ALT   = 3'd5;

    // one square root stage
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  val;
    } t_sq_st;

    // one divider stage: numerator bits shift out as quotient bits shift in
    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [NUM_W-1:0]  nq;
        logic [ROOT_W-1:0] dvs;
    } t_dv_st;

    function automatic t_sq_st sq_step(input t_sq_st s);
        t_sq_st            r;
        logic [REM_W+1:0]  t;
        logic [REM_W+1:0]  trial;
        logic              ge;
        t     = {s.rem, s.val[SUM_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        ge    = (t >= trial);
        r.rem  = ge ? REM_W'(t - trial) : t[REM_W-1:0];
        r.root = {s.root[ROOT_W-2:0], ge};
        r.val  = {s.val[SUM_W-3:0], 2'b00};
        return r;
    endfunction

    function automatic t_dv_st dv_step(input t_dv_st s);
        t_dv_st            r;
        logic [ROOT_W:0]   t;
        logic              ge;
        t    = {s.rem, s.nq[NUM_W-1]};
        ge   = (t >= {1'b0, s.dvs});
        r.rem = ge ? ROOT_W'(t - {1'b0, s.dvs}) : t[ROOT_W-1:0];
        r.nq  = {s.nq[NUM_W-2:0], ge};
        r.dvs = s.dvs;
        return r;
    endfunction

endpackage

>>> design/gsa_if.sv
// Stream interfaces for position samples and altitude targets.
interface gsa_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [gsa_pkg::XY_W-1:0]         pos_x;
    logic signed [gsa_pkg::XY_W-1:0]         pos_y;
    logic signed [gsa_pkg::ALT_W-1:0]        present_alt;

    modport source (output valid, pos_x, pos_y, present_alt, input ready);
    modport sink   (input valid, pos_x, pos_y, present_alt, output ready);
endinterface

interface gsa_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [gsa_pkg::ALT_W-1:0]        target_alt;
    logic [1:0]                              rule_used;

    modport source (output valid, target_alt, rule_used, input ready);
    modport sink   (input valid, target_alt, rule_used, output ready);
endinterface

>>> design/gsa_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module gsa_sqrt (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [gsa_pkg::SUM_W-1:0]        i_val,
    output logic [gsa_pkg::ROOT_W-1:0]       o_root
);

    gsa_pkg::t_sq_st r_st [gsa_pkg::SQ_STAGES];
    gsa_pkg::t_sq_st n_st [gsa_pkg::SQ_STAGES];

    // stage logic
    always_comb begin
        n_st[0] = gsa_pkg::sq_step({{gsa_pkg::REM_W{1'b0}}, {gsa_pkg::ROOT_W{1'b0}}, i_val});
        for (int k = 1; k < gsa_pkg::SQ_STAGES; k++) begin
            n_st[k] = gsa_pkg::sq_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[gsa_pkg::SQ_STAGES-1].root;

endmodule

>>> design/gsa_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module gsa_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [gsa_pkg::NUM_W-1:0]        i_num,
    input  logic [gsa_pkg::ROOT_W-1:0]       i_dvs,
    output logic [gsa_pkg::NUM_W-1:0]        o_quo
);

    gsa_pkg::t_dv_st r_st [gsa_pkg::DV_STAGES];
    gsa_pkg::t_dv_st n_st [gsa_pkg::DV_STAGES];

    // stage logic
    always_comb begin
        n_st[0] = gsa_pkg::dv_step({{gsa_pkg::ROOT_W{1'b0}}, i_num, i_dvs});
        for (int k = 1; k < gsa_pkg::DV_STAGES; k++) begin
            n_st[k] = gsa_pkg::dv_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quo = r_st[gsa_pkg::DV_STAGES-1].nq;

endmodule

>>> design/glide_slope_altitude.sv
// Top level: glide slope altitude target pipeline with APB register port.
// Pipeline: 3 front stages, 21 square root stages, 1 multiply stage, 40 divider
// stages and an output register; the accepting edge loads the first front stage.
// Throughput: one transaction per cycle; the whole pipeline holds on output stall,
// and a one-entry input skid buffer keeps input ready registered.
// Reset (synchronous, i_rst_n low): configuration registers to 0, pipeline valid bits and skid cleared.
module glide_slope_altitude (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gsa_pkg::ADDR_W-1:0]       paddr,
    input  logic [gsa_pkg::DATA_W-1:0]       pwdata,
    output logic [gsa_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    gsa_in_if.sink                           i_in,
    gsa_out_if.source                        o_out
);

    localparam int SQ = gsa_pkg::SQ_STAGES;
    localparam int DV = gsa_pkg::DV_STAGES;
    localparam int DIF_W = gsa_pkg::DIF_W;

    // configuration registers
    logic signed [gsa_pkg::XY_W-1:0]  r_start_x, r_start_y, r_end_x, r_end_y;
    logic signed [gsa_pkg::ALT_W-1:0] r_start_alt, r_end_alt;
    logic [2:0]                       w_idx;
    logic                             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_start_alt <= '0;
            r_end_x     <= '0;
            r_end_y     <= '0;
            r_end_alt   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                gsa_pkg::REG_START_X:   r_start_x   <= pwdata[gsa_pkg::XY_W-1:0];
                gsa_pkg::REG_START_Y:   r_start_y   <= pwdata[gsa_pkg::XY_W-1:0];
                gsa_pkg::REG_START_ALT: r_start_alt <= pwdata[gsa_pkg::ALT_W-1:0];
                gsa_pkg::REG_END_X:     r_end_x     <= pwdata[gsa_pkg::XY_W-1:0];
                gsa_pkg::REG_END_Y:     r_end_y     <= pwdata[gsa_pkg::XY_W-1:0];
                gsa_pkg::REG_END_ALT:   r_end_alt   <= pwdata[gsa_pkg::ALT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (w_idx)
            gsa_pkg::REG_START_X:   prdata = {12'b0, r_start_x};
            gsa_pkg::REG_START_Y:   prdata = {12'b0, r_start_y};
            gsa_pkg::REG_START_ALT: prdata = {14'b0, r_start_alt};
            gsa_pkg::REG_END_X:     prdata = {12'b0, r_end_x};
            gsa_pkg::REG_END_Y:     prdata = {12'b0, r_end_y};
            gsa_pkg::REG_END_ALT:   prdata = {14'b0, r_end_alt};
            default:                prdata = '0;
        endcase
    end

    // pipeline advance and input skid buffer
    logic                             w_en, w_acc, w_src_v;
    logic                             r_skid_v;
    logic signed [gsa_pkg::XY_W-1:0]  r_skid_x, r_skid_y, w_src_x, w_src_y;
    logic signed [gsa_pkg::ALT_W-1:0] r_skid_a, w_src_a;
    logic                             r_o_v;

    assign w_en       = !r_o_v || o_out.ready;
    assign i_in.ready = !r_skid_v;
    assign w_acc      = i_in.valid && !r_skid_v;
    assign w_src_v    = r_skid_v || w_acc;
    assign w_src_x    = r_skid_v ? r_skid_x : i_in.pos_x;
    assign w_src_y    = r_skid_v ? r_skid_y : i_in.pos_y;
    assign w_src_a    = r_skid_v ? r_skid_a : i_in.present_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= 1'b0;
        end else if (w_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_acc) begin
            r_skid_x <= i_in.pos_x;
            r_skid_y <= i_in.pos_y;
            r_skid_a <= i_in.present_alt;
        end
    end

    // stage A: coordinate differences, below-touchdown test
    logic                              r_a_v, r_a_clamp;
    logic signed [gsa_pkg::DIF_W-1:0]  r_a_rx, r_a_ry, r_a_hx, r_a_hy, r_a_ex, r_a_ey;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_clamp <= (w_src_a < r_end_alt);
            r_a_rx <= DIF_W'(r_start_x) - DIF_W'(r_end_x);
            r_a_ry <= DIF_W'(r_start_y) - DIF_W'(r_end_y);
            r_a_hx <= DIF_W'(r_start_x) - DIF_W'(w_src_x);
            r_a_hy <= DIF_W'(r_start_y) - DIF_W'(w_src_y);
            r_a_ex <= DIF_W'(r_end_x) - DIF_W'(w_src_x);
            r_a_ey <= DIF_W'(r_end_y) - DIF_W'(w_src_y);
        end
    end

    // stage B: squares
    logic                              r_b_v, r_b_clamp;
    logic [gsa_pkg::SQR_W-1:0]         r_b_rx, r_b_ry, r_b_hx, r_b_hy, r_b_ex, r_b_ey;
    logic signed [2*DIF_W-1:0]         w_p_rx, w_p_ry, w_p_hx, w_p_hy, w_p_ex, w_p_ey;

    assign w_p_rx = r_a_rx * r_a_rx;
    assign w_p_ry = r_a_ry * r_a_ry;
    assign w_p_hx = r_a_hx * r_a_hx;
    assign w_p_hy = r_a_hy * r_a_hy;
    assign w_p_ex = r_a_ex * r_a_ex;
    assign w_p_ey = r_a_ey * r_a_ey;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_clamp <= r_a_clamp;
            r_b_rx <= w_p_rx[gsa_pkg::SQR_W-1:0];
            r_b_ry <= w_p_ry[gsa_pkg::SQR_W-1:0];
            r_b_hx <= w_p_hx[gsa_pkg::SQR_W-1:0];
            r_b_hy <= w_p_hy[gsa_pkg::SQR_W-1:0];
            r_b_ex <= w_p_ex[gsa_pkg::SQR_W-1:0];
            r_b_ey <= w_p_ey[gsa_pkg::SQR_W-1:0];
        end
    end

    // stage C: sums of squares
    logic                              r_c_v, r_c_clamp;
    logic [gsa_pkg::SUM_W-1:0]         r_c_r, r_c_h, r_c_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_clamp <= r_b_clamp;
            r_c_r <= {1'b0, r_b_rx} + {1'b0, r_b_ry};
            r_c_h <= {1'b0, r_b_hx} + {1'b0, r_b_hy};
            r_c_e <= {1'b0, r_b_ex} + {1'b0, r_b_ey};
        end
    end

    // square root lanes: route, start-to-here, here-to-touchdown
    logic [gsa_pkg::ROOT_W-1:0]        w_route, w_here, w_to_end;
    logic [SQ-1:0]                     r_sq_v, r_sq_clamp;

    gsa_sqrt u_sqrt_route (.i_clk(i_clk), .i_en(w_en), .i_val(r_c_r), .o_root(w_route));
    gsa_sqrt u_sqrt_here  (.i_clk(i_clk), .i_en(w_en), .i_val(r_c_h), .o_root(w_here));
    gsa_sqrt u_sqrt_end   (.i_clk(i_clk), .i_en(w_en), .i_val(r_c_e), .o_root(w_to_end));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_clamp <= {r_sq_clamp[SQ-2:0], r_c_clamp};
        end
    end

    // stage D: rule select, |here * delta|
    logic                              r_d_v, r_d_neg;
    gsa_pkg::t_rule                    r_d_rule, w_d_rule;
    logic [gsa_pkg::NUM_W-1:0]         r_d_num;
    logic [gsa_pkg::ROOT_W-1:0]        r_d_route;
    logic signed [gsa_pkg::ALT_W:0]    w_delta;
    logic [gsa_pkg::ALT_W:0]           w_delta_mag;

    assign w_delta     = (gsa_pkg::ALT_W+1)'(r_end_alt) - (gsa_pkg::ALT_W+1)'(r_start_alt);
    assign w_delta_mag = w_delta[gsa_pkg::ALT_W] ? (gsa_pkg::ALT_W+1)'(-w_delta)
                                                 : w_delta;

    always_comb begin
        if (r_sq_clamp[SQ-1]) begin
            w_d_rule = gsa_pkg::RULE_CLAMP;
        end else if (w_route == '0 || w_route < w_to_end) begin
            w_d_rule = gsa_pkg::RULE_START;
        end else begin
            w_d_rule = gsa_pkg::RULE_INTERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rule  <= w_d_rule;
            r_d_neg   <= w_delta[gsa_pkg::ALT_W];
            r_d_num   <= gsa_pkg::NUM_W'(w_here * w_delta_mag);
            r_d_route <= w_route;
        end
    end

    // divider lane
    logic [gsa_pkg::NUM_W-1:0]         w_quo;
    logic [DV-1:0]                     r_dv_v, r_dv_neg;
    gsa_pkg::t_rule                    r_dv_rule [DV];

    gsa_div u_div (.i_clk(i_clk), .i_en(w_en), .i_num(r_d_num), .i_dvs(r_d_route),
                   .o_quo(w_quo));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_neg     <= {r_dv_neg[DV-2:0], r_d_neg};
            r_dv_rule[0] <= r_d_rule;
            for (int k = 1; k < DV; k++) begin
                r_dv_rule[k] <= r_dv_rule[k-1];
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_sq_v <= '0;
            r_d_v  <= 1'b0;
            r_dv_v <= '0;
            r_o_v  <= 1'b0;
        end else if (w_en) begin
            r_a_v  <= w_src_v;
            r_b_v  <= r_a_v;
            r_c_v  <= r_b_v;
            r_sq_v <= {r_sq_v[SQ-2:0], r_c_v};
            r_d_v  <= r_sq_v[SQ-1];
            r_dv_v <= {r_dv_v[DV-2:0], r_d_v};
            r_o_v  <= r_dv_v[DV-1];
        end
    end

    // output stage: apply sign, add start altitude, saturate, select result by rule
    localparam int OS_W = gsa_pkg::OUT_SUM_W;
    logic signed [OS_W-1:0]            w_q_s, w_sum;
    logic signed [gsa_pkg::ALT_W-1:0]  w_interp, n_o_alt;
    logic signed [gsa_pkg::ALT_W-1:0]  r_o_alt;
    gsa_pkg::t_rule                    r_o_rule;

    assign w_q_s = r_dv_neg[DV-1] ? -$signed({2'b00, w_quo}) : $signed({2'b00, w_quo});
    assign w_sum = w_q_s + OS_W'(r_start_alt);

    always_comb begin
        if (w_sum < OS_W'(gsa_pkg::ALT_MIN)) begin
            w_interp = gsa_pkg::ALT_MIN;
        end else if (w_sum > OS_W'(gsa_pkg::ALT_MAX)) begin
            w_interp = gsa_pkg::ALT_MAX;
        end else begin
            w_interp = w_sum[gsa_pkg::ALT_W-1:0];
        end
        case (r_dv_rule[DV-1])
            gsa_pkg::RULE_CLAMP: n_o_alt = r_end_alt;
            gsa_pkg::RULE_START: n_o_alt = r_start_alt;
            default:             n_o_alt = w_interp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_alt  <= n_o_alt;
            r_o_rule <= r_dv_rule[DV-1];
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.target_alt = r_o_alt;
    assign o_out.rule_used  = r_o_rule;

    // checks
    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_rule == gsa_pkg::RULE_CLAMP) |-> (r_o_alt == r_end_alt))
        else $error("clamp result differs from touchdown altitude");

    a_start_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_rule == gsa_pkg::RULE_START) |-> (r_o_alt == r_start_alt))
        else $error("start-hold result differs from start altitude");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(!w_en))
        else $error("skid buffer filled while pipeline was advancing");

endmodule
